>>> rtl/core/o2p_pkg.sv
// shared types and constants for the order-2 predictor codec
`timescale 1ns / 1ps
package o2p_pkg;

  // prediction table geometry: indexed by {prev_prev_byte, prev_byte}
  localparam int unsigned ByteW        = 8;
  localparam int unsigned TableAw      = 2 * ByteW;
  localparam int unsigned TableEntries = 1 << TableAw;

  // stream position saturates here; below it a byte passes verbatim
  localparam logic [1:0] PosSteady = 2'd2;

  // request mode codes
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [TableAw-1:0] tbl_addr_t;

  // table read port request
  typedef struct packed {
    logic      en;
    tbl_addr_t addr;
  } rd_req_t;

  // table write port request
  typedef struct packed {
    logic      en;
    tbl_addr_t addr;
    byte_t     data;
  } wr_req_t;

  // one coded result
  typedef struct packed {
    logic  raw;
    logic  hit;
    byte_t data;
  } result_t;

endpackage

>>> rtl/core/o2p_table.sv
// prediction table memory with reset clearing sweep and write-to-read forwarding
`timescale 1ns / 1ps
module o2p_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  o2p_pkg::rd_req_t rd_req_i,
  input  o2p_pkg::wr_req_t wr_req_i,
  output o2p_pkg::byte_t   pred_o,
  output logic             ready_o
);

  typedef enum logic [1:0] {
    StClear = 2'b01,
    StRun   = 2'b10
  } tbl_state_e;

  tbl_state_e           state_q, state_d;
  o2p_pkg::tbl_addr_t   clr_addr_q, clr_addr_d;

  o2p_pkg::byte_t       mem [o2p_pkg::TableEntries];
  o2p_pkg::byte_t       rd_data_q;
  logic                 fwd_q;
  o2p_pkg::byte_t       fwd_data_q;

  logic                 mem_we;
  o2p_pkg::tbl_addr_t   mem_waddr;
  o2p_pkg::byte_t       mem_wdata;

  // clearing sequencer
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      StClear: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = StRun;
        end
      end
      StRun: begin
        state_d = StRun;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign ready_o = (state_q == StRun);

  // write port shared by the sweep and the update path
  always_comb begin
    if (state_q == StClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_req_i.en;
      mem_waddr = wr_req_i.addr;
      mem_wdata = wr_req_i.data;
    end
  end

  // memory array, synchronous read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_req_i.en) begin
      rd_data_q <= mem[rd_req_i.addr];
    end
  end

  // catch a write landing on the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_req_i.en) begin
      fwd_q <= wr_req_i.en && (wr_req_i.addr == rd_req_i.addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      fwd_data_q <= wr_req_i.data;
    end
  end

  assign pred_o = fwd_q ? fwd_data_q : rd_data_q;

endmodule

>>> rtl/core/o2p_core.sv
// coding stage: context history, stream position, hit/miss decision and table update
`timescale 1ns / 1ps
module o2p_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              mode_i,
  input  logic              stream_start_i,
  input  logic              hit_in_i,
  input  o2p_pkg::byte_t    byte_in_i,
  input  logic              advance_i,
  input  o2p_pkg::byte_t    pred_i,
  output logic              busy_o,
  output o2p_pkg::rd_req_t  rd_req_o,
  output o2p_pkg::wr_req_t  wr_req_o,
  output o2p_pkg::result_t  result_o
);

  logic            busy_q;
  logic            mode_q;
  logic            start_q;
  logic            hit_q;
  o2p_pkg::byte_t  byte_q;

  o2p_pkg::byte_t  prev_q, prev_d;
  o2p_pkg::byte_t  prev2_q, prev2_d;
  logic [1:0]      pos_q, pos_d;

  logic [1:0]      pos_eff;
  logic            raw;
  logic            miss;
  logic            done;
  o2p_pkg::byte_t  cur;

  // stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept_i) begin
      busy_q <= 1'b1;
    end else if (advance_i) begin
      busy_q <= 1'b0;
    end
  end

  // request payload held for the stage
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mode_q  <= mode_i;
      start_q <= stream_start_i;
      hit_q   <= hit_in_i;
      byte_q  <= byte_in_i;
    end
  end

  assign done    = busy_q && advance_i;
  assign pos_eff = start_q ? 2'd0 : pos_q;
  assign raw     = (pos_eff < o2p_pkg::PosSteady);

  // coding decision against the table prediction
  always_comb begin
    result_o.raw = raw;
    if (raw) begin
      result_o.hit  = 1'b0;
      result_o.data = byte_q;
      cur           = byte_q;
      miss          = 1'b0;
    end else if (mode_q == o2p_pkg::ModeDecode) begin
      result_o.hit  = hit_q;
      cur           = hit_q ? pred_i : byte_q;
      result_o.data = cur;
      miss          = !hit_q;
    end else begin
      result_o.hit  = (pred_i == byte_q);
      result_o.data = result_o.hit ? '0 : byte_q;
      cur           = byte_q;
      miss          = !result_o.hit;
    end
  end

  // table update on a miss
  assign wr_req_o.en   = done && miss;
  assign wr_req_o.addr = {prev2_q, prev_q};
  assign wr_req_o.data = byte_q;

  // next lookup uses the history as it stands after the item in flight
  assign rd_req_o.en   = accept_i;
  assign rd_req_o.addr = busy_q ? {prev_q, cur} : {prev2_q, prev_q};

  // history and position advance when the item leaves the stage
  always_comb begin
    prev_d  = prev_q;
    prev2_d = prev2_q;
    pos_d   = pos_q;
    if (done) begin
      prev2_d = prev_q;
      prev_d  = cur;
      pos_d   = raw ? pos_eff + 2'd1 : o2p_pkg::PosSteady;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      prev2_q <= '0;
      pos_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
      pos_q   <= pos_d;
    end
  end

  assign busy_o = busy_q;

endmodule

>>> rtl/core/order2_byte_predictor_codec_top.sv
// top level of the order-2 predictor codec: handshake, output register, checks
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | request   | in_valid_i/in_stall_o | mode_i stream_start_i hit_in_i byte_in_i
//  out     | result    | out_valid_o/out_stall_i | raw_out_o hit_out_o byte_out_o
//
// one request per cycle sustained while in_stall_o stays low; the table read is
// issued as a request is accepted, and the request moves from the coding stage
// (coding and table write-back) into the output register, from which its result is taken.
// the table read for the next request is issued from the history of the one
// in flight; a same-entry write is forwarded into the read.
// after reset the table is swept to zero, all 65536 entries; in_stall_o is high
// throughout. an output stall backs up into in_stall_o only once the coding
// stage is also full.
`timescale 1ns / 1ps
module order2_byte_predictor_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic       stream_start_i,
  input  logic       hit_in_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       raw_out_o,
  output logic       hit_out_o,
  output logic [7:0] byte_out_o
);

  logic              tbl_ready;
  logic              core_busy;
  logic              advance;
  logic              accept;
  o2p_pkg::rd_req_t  rd_req;
  o2p_pkg::wr_req_t  wr_req;
  o2p_pkg::byte_t    pred;
  o2p_pkg::result_t  result;

  logic              out_valid_q;
  o2p_pkg::result_t  out_q;

  // handshake control
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !tbl_ready || (core_busy && !advance);
  assign accept     = in_valid_i && !in_stall_o;

  o2p_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .wr_req_i (wr_req),
    .pred_o   (pred),
    .ready_o  (tbl_ready)
  );

  o2p_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .mode_i         (mode_i),
    .stream_start_i (stream_start_i),
    .hit_in_i       (hit_in_i),
    .byte_in_i      (byte_in_i),
    .advance_i      (advance),
    .pred_i         (pred),
    .busy_o         (core_busy),
    .rd_req_o       (rd_req),
    .wr_req_o       (wr_req),
    .result_o       (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_busy && advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_busy && advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign raw_out_o   = out_q.raw;
  assign hit_out_o   = out_q.hit;
  assign byte_out_o  = out_q.data;

  // raw bytes never report a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && raw_out_o |-> !hit_out_o)
    else $error("raw result flagged as hit");

  // an accepted request occupies the coding stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> core_busy)
    else $error("accepted request lost before coding stage");

  // no coding work while the table is still being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_busy |-> tbl_ready)
    else $error("coding stage active during table clear");

  // table is never read and written by the sweep in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tbl_ready |-> !rd_req.en && !wr_req.en)
    else $error("table access during clearing sweep");

endmodule
